FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("allocator assertion failed");
`define ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("allocator assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ANY(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// No dependencies.
package gha_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_AW = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int IDX_W   = 8;
    localparam int KEY_W   = 32;
    localparam int FREE_W  = 9;

    localparam logic [KEY_W-1:0] INVALID_KEY = '0;
    localparam logic [KEY_W-1:0] FIRST_KEY   = INVALID_KEY + KEY_W'(1);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_STALE = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  slot_index;
        logic [KEY_W-1:0]  handle_key;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  out_index;
        logic [KEY_W-1:0]  out_key;
        logic [FREE_W-1:0] free_slots;
    } out_item_t;

endpackage

FILE: rtl/core/gha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/generational_handle_allocator_top.sv
// Generational handle allocator top level: key table and LIFO free stack in RAM.
// Depends on gha_pkg, gha_ram and assert_macros.svh.
//
// After reset a clearing pass over all SLOTS (256) slots writes the reset contents
// into both memories, the invalid key into every slot and the descending indices
// into the free stack. s_ready stays low until it ends. After that, in the accept
// cycle the RAMs read the key table and the top of the free stack. In the S_EXEC
// state the block uses the returned data, writes both memories back and loads the
// result register. An item is accepted while a finished result still waits in the
// output register. Only the write-back step waits for that result to be taken.
`include "assert_macros.svh"

module generational_handle_allocator_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gha_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output gha_pkg::out_item_t m_item
);

    typedef enum logic [2:0] {
        S_INIT = 3'b001,
        S_IDLE = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    gha_pkg::cmd_t                 cmd_reg;
    logic [gha_pkg::IDX_W-1:0]     idx_reg;
    logic [gha_pkg::KEY_W-1:0]     hkey_reg;
    logic [gha_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [gha_pkg::KEY_W-1:0]     nkey_reg, nkey_next;
    logic                          out_vld_reg, out_vld_next;
    gha_pkg::out_item_t            out_reg, out_next;
    logic [gha_pkg::SLOT_AW-1:0]   clr_reg, clr_next;

    logic                          accept;
    logic                          go;
    logic [gha_pkg::SLOT_AW-1:0]   key_raddr;
    logic [gha_pkg::SLOT_AW-1:0]   stk_raddr;
    logic [gha_pkg::KEY_W-1:0]     key_q;
    logic [gha_pkg::SLOT_AW-1:0]   stk_q;
    logic [gha_pkg::SLOT_AW-1:0]   slot;

    logic                          key_we;
    logic [gha_pkg::SLOT_AW-1:0]   key_waddr;
    logic [gha_pkg::KEY_W-1:0]     key_wdata;
    logic                          stk_we;
    logic [gha_pkg::SLOT_AW-1:0]   stk_waddr;
    logic [gha_pkg::SLOT_AW-1:0]   stk_wdata;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign go        = (state_reg == S_EXEC) && (!out_vld_reg || m_ready);
    assign m_valid   = out_vld_reg;
    assign m_item    = out_reg;

    assign key_raddr = gha_pkg::SLOT_AW'(s_item.slot_index);
    assign stk_raddr = gha_pkg::SLOT_AW'(cnt_reg - gha_pkg::CNT_W'(1));

    gha_ram #(
        .WIDTH (gha_pkg::KEY_W),
        .DEPTH (gha_pkg::SLOTS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (accept),
        .raddr (key_raddr),
        .rdata (key_q)
    );

    gha_ram #(
        .WIDTH (gha_pkg::SLOT_AW),
        .DEPTH (gha_pkg::SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    assign slot = (32'(stk_q) >= 32'(gha_pkg::SLOTS)) ? '0 : stk_q;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        nkey_next    = nkey_reg;
        clr_next     = clr_reg;
        out_vld_next = out_vld_reg && !m_ready;
        out_next     = out_reg;
        key_we       = 1'b0;
        key_waddr    = slot;
        key_wdata    = nkey_reg;
        stk_we       = 1'b0;
        stk_waddr    = gha_pkg::SLOT_AW'(cnt_reg);
        stk_wdata    = gha_pkg::SLOT_AW'(idx_reg);
        unique case (state_reg)
            S_INIT: begin
                key_we    = 1'b1;
                key_waddr = clr_reg;
                key_wdata = gha_pkg::INVALID_KEY;
                stk_we    = 1'b1;
                stk_waddr = clr_reg;
                stk_wdata = gha_pkg::SLOT_AW'(gha_pkg::SLOTS - 1) - clr_reg;
                clr_next  = clr_reg + gha_pkg::SLOT_AW'(1);
                if (clr_reg == gha_pkg::SLOT_AW'(gha_pkg::SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go) begin
                    state_next   = S_IDLE;
                    out_vld_next = 1'b1;
                    priority if (cmd_reg == gha_pkg::CMD_ALLOC) begin
                        if (cnt_reg == '0) begin
                            out_next.status    = gha_pkg::STAT_EMPTY;
                            out_next.out_index = '0;
                            out_next.out_key   = '0;
                        end else begin
                            key_we    = 1'b1;
                            cnt_next  = cnt_reg - gha_pkg::CNT_W'(1);
                            nkey_next = (nkey_reg == '1) ? gha_pkg::FIRST_KEY
                                      : nkey_reg + gha_pkg::KEY_W'(1);
                            out_next.status    = gha_pkg::STAT_OK;
                            out_next.out_index = gha_pkg::IDX_W'(slot);
                            out_next.out_key   = nkey_reg;
                        end
                    end else if (32'(idx_reg) >= 32'(gha_pkg::SLOTS)) begin
                        out_next.status    = gha_pkg::STAT_RANGE;
                        out_next.out_index = idx_reg;
                        out_next.out_key   = '0;
                    end else if (hkey_reg == gha_pkg::INVALID_KEY
                                 || key_q != hkey_reg) begin
                        out_next.status    = gha_pkg::STAT_STALE;
                        out_next.out_index = idx_reg;
                        out_next.out_key   = key_q;
                    end else begin
                        if (cmd_reg == gha_pkg::CMD_RELEASE) begin
                            key_we    = 1'b1;
                            key_waddr = gha_pkg::SLOT_AW'(idx_reg);
                            key_wdata = gha_pkg::INVALID_KEY;
                            if (cnt_reg < gha_pkg::CNT_W'(gha_pkg::SLOTS)) begin
                                stk_we   = 1'b1;
                                cnt_next = cnt_reg + gha_pkg::CNT_W'(1);
                            end
                        end
                        out_next.status    = gha_pkg::STAT_OK;
                        out_next.out_index = idx_reg;
                        out_next.out_key   = key_q;
                    end
                    out_next.free_slots = gha_pkg::FREE_W'(cnt_next);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cnt_reg     <= gha_pkg::CNT_W'(gha_pkg::SLOTS);
            nkey_reg    <= gha_pkg::FIRST_KEY;
            out_vld_reg <= 1'b0;
            clr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            nkey_reg    <= nkey_next;
            out_vld_reg <= out_vld_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (accept) begin
            cmd_reg  <= s_item.cmd;
            idx_reg  <= s_item.slot_index;
            hkey_reg <= s_item.handle_key;
        end
    end

    `ASSERT_CLK(a_cnt_bound, aclk, aresetn, cnt_reg <= gha_pkg::CNT_W'(gha_pkg::SLOTS))
    `ASSERT_CLK(a_key_nonzero, aclk, aresetn, nkey_reg != gha_pkg::INVALID_KEY)
    `ASSERT_CLK(a_accept_exec, aclk, aresetn, accept |=> state_reg == S_EXEC)
    `ASSERT_CLK(a_alloc_pop, aclk, aresetn, (go && key_we && cmd_reg == gha_pkg::CMD_ALLOC) |=> cnt_reg == $past(cnt_reg) - gha_pkg::CNT_W'(1))
    `ASSERT_CLK(a_exec_stall, aclk, aresetn, (state_reg == S_EXEC && out_vld_reg && !m_ready) |=> state_reg == S_EXEC)

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for generational_handle_allocator_top: allocate, release
// and check traffic against an in-bench model of the key table and free stack.
// Depends on gha_pkg and the allocator RTL.
module tb_top;

    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        logic [gha_pkg::IDX_W-1:0] idx;
        logic [gha_pkg::KEY_W-1:0] key;
    } handle_t;

    typedef enum {RX_OPEN, RX_COIN, RX_TOGGLE, RX_HOLD} rx_mode_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    gha_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    gha_pkg::out_item_t m_item;

    // allocator model state
    logic [gha_pkg::KEY_W-1:0] pool_keys  [gha_pkg::SLOTS];
    logic [gha_pkg::IDX_W-1:0] pool_stack [gha_pkg::SLOTS];
    int                        pool_free;
    logic [gha_pkg::KEY_W-1:0] pool_next_key;

    gha_pkg::out_item_t        pending_results [$];
    logic [gha_pkg::IDX_W-1:0] live_slots [$];
    handle_t                   retired_handles [$];

    int       error_count = 0;
    int       items_sent  = 0;
    int       results_seen = 0;
    int       status_seen [4] = '{0, 0, 0, 0};
    int       burst_left  = 1;
    int       gap_left    = 0;
    int       idle_cycles = 0;
    int       rx_left     = 0;
    rx_mode_t rx_mode     = RX_OPEN;

    generational_handle_allocator_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic reset_pool();
        for (int i = 0; i < gha_pkg::SLOTS; i++) begin
            pool_keys[i]  = gha_pkg::INVALID_KEY;
            pool_stack[i] = gha_pkg::IDX_W'(gha_pkg::SLOTS - 1 - i);
        end
        pool_free     = gha_pkg::SLOTS;
        pool_next_key = gha_pkg::FIRST_KEY;
    endtask

    function automatic gha_pkg::out_item_t predict_handle_op(gha_pkg::in_item_t it);
        gha_pkg::out_item_t        r;
        logic [gha_pkg::IDX_W-1:0] slot;
        logic [gha_pkg::KEY_W-1:0] stored;
        r = '0;
        if (it.cmd == gha_pkg::CMD_ALLOC) begin
            if (pool_free == 0) begin
                r.status = gha_pkg::STAT_EMPTY;
            end else begin
                pool_free--;
                slot            = pool_stack[pool_free];
                pool_keys[slot] = pool_next_key;
                r.status        = gha_pkg::STAT_OK;
                r.out_index     = slot;
                r.out_key       = pool_next_key;
                pool_next_key++;
                if (pool_next_key == gha_pkg::INVALID_KEY) begin
                    pool_next_key = gha_pkg::FIRST_KEY;
                end
            end
        end else if (int'(it.slot_index) >= gha_pkg::SLOTS) begin
            r.status    = gha_pkg::STAT_RANGE;
            r.out_index = it.slot_index;
        end else begin
            stored      = pool_keys[it.slot_index];
            r.out_index = it.slot_index;
            r.out_key   = stored;
            if (it.handle_key == gha_pkg::INVALID_KEY || stored != it.handle_key) begin
                r.status = gha_pkg::STAT_STALE;
            end else begin
                r.status = gha_pkg::STAT_OK;
                if (it.cmd == gha_pkg::CMD_RELEASE) begin
                    pool_keys[it.slot_index] = gha_pkg::INVALID_KEY;
                    if (pool_free < gha_pkg::SLOTS) begin
                        pool_stack[pool_free] = it.slot_index;
                        pool_free++;
                    end
                end
            end
        end
        r.free_slots = gha_pkg::FREE_W'(pool_free);
        return r;
    endfunction

    function automatic gha_pkg::in_item_t make_item(gha_pkg::cmd_t cmd,
                                                    logic [gha_pkg::IDX_W-1:0] idx,
                                                    logic [gha_pkg::KEY_W-1:0] key);
        gha_pkg::in_item_t it;
        it.cmd        = cmd;
        it.slot_index = idx;
        it.handle_key = key;
        return it;
    endfunction

    task automatic send_item(gha_pkg::in_item_t it);
        gha_pkg::out_item_t r;
        handle_t            h;
        if (gap_left > 0) begin
            s_valid <= 1'b0;
            repeat (gap_left) @(posedge aclk);
            gap_left = 0;
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = predict_handle_op(it);
        pending_results.insert(pending_results.size(), r);
        items_sent++;
        if (r.status == gha_pkg::STAT_OK && it.cmd == gha_pkg::CMD_ALLOC) begin
            live_slots.insert(live_slots.size(), r.out_index);
        end
        if (r.status == gha_pkg::STAT_OK && it.cmd == gha_pkg::CMD_RELEASE) begin
            foreach (live_slots[i]) begin
                if (live_slots[i] == it.slot_index) begin
                    live_slots.delete(i);
                    break;
                end
            end
            h.idx = it.slot_index;
            h.key = it.handle_key;
            retired_handles.insert(retired_handles.size(), h);
            if (retired_handles.size() > 32) begin
                retired_handles.delete(0);
            end
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
    endtask

    task automatic send_alloc();
        send_item(make_item(gha_pkg::CMD_ALLOC, gha_pkg::IDX_W'($urandom),
                            gha_pkg::KEY_W'($urandom)));
    endtask

    // operate on a random live handle with its current key
    task automatic send_live(gha_pkg::cmd_t cmd);
        logic [gha_pkg::IDX_W-1:0] idx;
        idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
        send_item(make_item(cmd, idx, pool_keys[idx]));
    endtask

    task automatic send_retired();
        handle_t h;
        h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
        send_item(make_item($urandom_range(0, 1) ? gha_pkg::CMD_RELEASE : gha_pkg::CMD_CHECK,
                            h.idx, h.key));
    endtask

    task automatic send_noise();
        logic [gha_pkg::IDX_W-1:0] idx;
        logic [gha_pkg::KEY_W-1:0] key;
        idx = gha_pkg::IDX_W'($urandom);
        case ($urandom_range(0, 3))
            0:       key = gha_pkg::INVALID_KEY;
            1:       key = pool_keys[idx];
            default: key = gha_pkg::KEY_W'($urandom);
        endcase
        send_item(make_item(gha_pkg::cmd_t'($urandom_range(0, 3)), idx, key));
    endtask

    task automatic test_directed();
        send_item(make_item(gha_pkg::CMD_CHECK, 8'h00, gha_pkg::INVALID_KEY));
        send_item(make_item(gha_pkg::CMD_CHECK, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h00, gha_pkg::FIRST_KEY));
        send_alloc();
        send_alloc();
        send_alloc();
        send_item(make_item(gha_pkg::CMD_CHECK, 8'h00, pool_keys[0]));
        send_item(make_item(gha_pkg::CMD_RSVD, 8'h01, pool_keys[1]));
        send_item(make_item(gha_pkg::CMD_RSVD, 8'h01, pool_keys[1] + 1));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h01, pool_keys[1]));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h01, 32'd2));
        send_item(make_item(gha_pkg::CMD_CHECK, 8'h01, 32'd2));
        send_alloc();
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h01, 32'd2));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h01, gha_pkg::INVALID_KEY));
        send_item(make_item(gha_pkg::CMD_CHECK, 8'hAA, 32'h5555_5555));
        send_item(make_item(gha_pkg::CMD_CHECK, 8'h55, 32'hAAAA_AAAA));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h00, pool_keys[0]));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h02, pool_keys[2]));
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h01, pool_keys[1]));
        send_item(make_item(gha_pkg::CMD_CHECK, 8'h01, 32'd4));
    endtask

    task automatic test_pool_exhaust();
        while (pool_free > 0) send_alloc();
        send_alloc();
        send_alloc();
        send_live(gha_pkg::CMD_RELEASE);
        send_alloc();
        send_alloc();
        send_live(gha_pkg::CMD_RSVD);
        while (live_slots.size() > 0) begin
            if (retired_handles.size() > 0 && $urandom_range(0, 7) == 0) begin
                send_retired();
            end else begin
                send_live(gha_pkg::CMD_RELEASE);
            end
        end
        send_item(make_item(gha_pkg::CMD_RELEASE, 8'h00, pool_keys[0]));
    endtask

    task automatic test_random_mix(int count);
        int roll;
        int alloc_w;
        for (int n = 0; n < count; n++) begin
            roll    = $urandom_range(0, 99);
            alloc_w = ((n / 50) % 2 == 0) ? 45 : 15;
            if (live_slots.size() == 0 || roll < alloc_w) begin
                send_alloc();
            end else if (roll < alloc_w + 30) begin
                send_live(gha_pkg::CMD_RELEASE);
            end else if (roll < alloc_w + 42) begin
                send_live($urandom_range(0, 1) ? gha_pkg::CMD_CHECK : gha_pkg::CMD_RSVD);
            end else if (roll < alloc_w + 50 && retired_handles.size() > 0) begin
                send_retired();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic report_field(string name, logic [gha_pkg::KEY_W-1:0] exp_v,
                                logic [gha_pkg::KEY_W-1:0] act_v);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_v, act_v);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin
        gha_pkg::out_item_t exp_r;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual 0x%0h",
                         $time, m_item);
                error_count++;
            end else begin
                exp_r = pending_results[0];
                pending_results.delete(0);
                status_seen[exp_r.status]++;
                if (m_item.status !== exp_r.status)
                    report_field("status", exp_r.status, m_item.status);
                if (m_item.out_index !== exp_r.out_index)
                    report_field("out_index", exp_r.out_index, m_item.out_index);
                if (m_item.out_key !== exp_r.out_key)
                    report_field("out_key", exp_r.out_key, m_item.out_key);
                if (m_item.free_slots !== exp_r.free_slots)
                    report_field("free_slots", exp_r.free_slots, m_item.free_slots);
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 32) : $urandom_range(8, 80);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_TOGGLE: m_ready <= ~m_ready;
            default:   m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        reset_pool();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pool_exhaust();
        test_random_mix(420);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("Summary: %0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, error_count);
        $display("Status mix: ok %0d, pool empty %0d, stale key %0d, out of range %0d",
                 status_seen[gha_pkg::STAT_OK], status_seen[gha_pkg::STAT_EMPTY],
                 status_seen[gha_pkg::STAT_STALE], status_seen[gha_pkg::STAT_RANGE]);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
